// ----- src/md5cc_pkg.sv -----
// Package for the MD5 candidate checker: round constants, shift amounts,
// message word selection and round step function. No dependencies.
package md5cc_pkg;

  localparam int unsigned Rounds = 64;
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // Register offsets on the config port (8-byte spacing)
  localparam logic [3:0] RegTargetLow  = 4'h0;
  localparam logic [3:0] RegTargetHigh = 4'h8;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_state_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      unique case (i)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] r;
    begin
      unique case ({i[5:4], i[1:0]})
        4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
        4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
        4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
        4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
    end
  endfunction

  // Message word index for round i
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    begin
      unique case (i[5:4])
        2'd0: g = i[3:0];
        2'd1: g = 4'(5 * i[3:0] + 1);
        2'd2: g = 4'(3 * i[3:0] + 5);
        default: g = 4'(7 * i[3:0]);
      endcase
      return g;
    end
  endfunction

  // One MD5 round on state s with message word m
  function automatic md5_state_t md5_round(input md5_state_t s, input logic [5:0] i,
                                           input logic [31:0] m);
    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  r;
    md5_state_t  o;
    begin
      unique case (i[5:4])
        2'd0: f = (s.b & s.c) | (~s.b & s.d);
        2'd1: f = (s.d & s.b) | (~s.d & s.c);
        2'd2: f = s.b ^ s.c ^ s.d;
        default: f = s.c ^ (s.b | ~s.d);
      endcase
      sum = s.a + f + md5_k(i) + m;
      r = md5_rot(i);
      o.a = s.d;
      o.d = s.c;
      o.c = s.b;
      o.b = s.b + ((sum << r) | (sum >> (6'd32 - {1'b0, r})));
      return o;
    end
  endfunction

endpackage

// ----- src/md5_candidate_checker.sv -----
// Top level of the MD5 candidate checker: config registers, 64-stage round
// pipeline, final add and compare stage. Depends on md5cc_pkg.
//
// Usage
//   s_axis: one candidate request per beat, s_tdata[31:0] = password bytes,
//     first character in the low byte. Bytes at and above PASSWORD_LENGTH are
//     not hashed but are echoed back.
//   m_axis: one result per candidate, in order. m_tdata packs candidate_out,
//     is_match, digest_low, digest_high from bit 0 up, padded to 168 bits.
//   APB: target_digest_low at 0x0, target_digest_high at 0x8, 64-bit data,
//     both reset to zero. Write them only while the pipeline is empty.
// Pipeline: an input register (stage 0), one register per MD5 round, then one
//   stage for the final add and digest compare.
// Throughput: one candidate per cycle while the output is not stalled; the
//   rounds are fully unrolled, so each round register takes a new item every cycle it advances.
// Stall: each stage advances when the stage after it advances or when it is
//   empty; when m_tready is low and the output stage is full, occupied stages
//   hold, bubbles close up, and s_tready drops only once every stage is full.
// Reset: rst clears all stage valid bits and the target registers.
module md5_candidate_checker
  import md5cc_pkg::*;
#(
  parameter int PASSWORD_LENGTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  // APB config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // candidate requests
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] candidate
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata    // [31:0] candidate_out, [32] is_match,
                                  // [96:33] digest_low, [160:97] digest_high
);

  localparam int Len = (PASSWORD_LENGTH < 1) ? 1 : ((PASSWORD_LENGTH > 8) ? 8 : PASSWORD_LENGTH);

  logic [63:0] target_low;
  logic [63:0] target_high;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_low  <= '0;
      target_high <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegTargetLow)  target_low  <= pwdata;
      if (paddr == RegTargetHigh) target_high <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegTargetLow)  prdata = target_low;
    if (paddr == RegTargetHigh) prdata = target_high;
  end

  // Padded message block built from a candidate (only words 0..2 and 14 can be nonzero)
  function automatic logic [511:0] build_block(input logic [31:0] cand);
    logic [511:0] blk;
    begin
      blk = '0;
      for (int i = 0; i < Len; i++) begin
        if (i < 4) blk[8*i +: 8] = cand[8*i +: 8];
      end
      blk[8*Len +: 8] = 8'h80;
      blk[448 +: 8]   = 8'(Len * 8);
      return blk;
    end
  endfunction

  // Round pipeline: stage j holds the state after j rounds
  md5_state_t  st   [Rounds+1];
  logic [31:0] cand [Rounds+1];
  logic        vld  [Rounds+1];
  logic        adv  [Rounds+1];

  // Output stage
  logic         out_vld;
  logic [31:0]  out_cand;
  logic [127:0] out_dig;
  logic         out_match;
  logic         out_adv;

  assign out_adv = !out_vld || m_tready;

  // stage k advances when downstream can take it or it is empty
  always_comb begin
    adv[Rounds] = out_adv || !vld[Rounds];
    for (int k = Rounds - 1; k >= 0; k--) adv[k] = adv[k+1] || !vld[k];
  end

  assign s_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Rounds; k++) vld[k] <= 1'b0;
    end else begin
      if (adv[0]) vld[0] <= s_tvalid;
      for (int k = 1; k <= Rounds; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0 registers the candidate with the initial chaining values
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cand[0] <= s_tdata;
      st[0]   <= '{a: InitA, b: InitB, c: InitC, d: InitD};
    end
  end

  for (genvar j = 0; j < Rounds; j++) begin : g_round
    logic [511:0] blk;
    logic [3:0]   gi;
    assign blk = build_block(cand[j]);
    assign gi  = md5_g(6'(j));
    always_ff @(posedge clk) begin
      if (adv[j+1]) begin
        cand[j+1] <= cand[j];
        st[j+1]   <= md5_round(st[j], 6'(j), blk[32*gi +: 32]);
      end
    end
  end

  // final add and compare
  logic [127:0] dig_next;
  assign dig_next = {st[Rounds].d + InitD, st[Rounds].c + InitC,
                     st[Rounds].b + InitB, st[Rounds].a + InitA};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_adv) begin
      out_vld <= vld[Rounds];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_cand  <= cand[Rounds];
      out_dig   <= dig_next;
      out_match <= (dig_next == {target_high, target_low});
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {7'b0, out_dig, out_match, out_cand};

endmodule

// ----- src/md5cc_checker.sv -----
// Port-level checks for md5_candidate_checker, bound to the top level.
// Imports md5cc_pkg; attached by the bind statement at the end of this file.
module md5cc_assertions
  import md5cc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [167:0] m_tdata,
  input logic         pready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // nothing comes out the cycle after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // an empty output always lets requests in
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind md5_candidate_checker md5cc_assertions u_md5cc_assertions (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
